FILE: hdl/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// shared constants, datapath command codes and control structs for the
// xxh64 stream hash
// ----------------------------------------------------------------------------
package xxh_pkg;

  localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
  localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
  localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
  localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
  localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

  localparam int unsigned STRIPE_BYTES = 32;

  typedef enum logic [3:0] {
    X_HOLD,
    X_LOAD_BUF,
    X_LOAD_LANE,
    X_LOAD_TAIL32,
    X_LOAD_BYTE,
    X_MUL_RES,
    X_ADD_LANE_ROT,
    X_ROT,
    X_MIX,
    X_AVAL
  } x_op_e;

  typedef enum logic [2:0] {
    H_HOLD,
    H_MERGE,
    H_SEED,
    H_ADD_TOTAL,
    H_FROM_X
  } h_op_e;

  typedef enum logic [1:0] {
    K_P1,
    K_P2,
    K_P3,
    K_P5
  } ksel_e;

  typedef enum logic [1:0] {
    C_ZERO,
    C_P3,
    C_P4
  } csel_e;

  typedef enum logic [1:0] {
    R_NONE,
    R_27,
    R_23,
    R_11
  } rsel_e;

  typedef enum logic [1:0] {
    SH_33,
    SH_29,
    SH_32
  } shsel_e;

  typedef struct packed {
    x_op_e       x_op;
    h_op_e       h_op;
    ksel_e       ksel;
    csel_e       csel;
    rsel_e       rsel;
    shsel_e      shsel;
    logic [2:0]  idx;
    logic        accept;
    logic        lane_wr;
    logic        restart;
    logic        mul_start;
    logic        out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] buffered;
    logic [3:0] tail_n;
    logic       long_msg;
    logic       mul_done;
  } status_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] kval(input ksel_e k);
    logic [63:0] v;
    case (k)
      K_P1:    v = PRIME1;
      K_P2:    v = PRIME2;
      K_P3:    v = PRIME3;
      K_P5:    v = PRIME5;
      default: v = PRIME1;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] cval(input csel_e c);
    logic [63:0] v;
    case (c)
      C_ZERO:  v = 64'd0;
      C_P3:    v = PRIME3;
      C_P4:    v = PRIME4;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/xxh_mul64.sv
// ----------------------------------------------------------------------------
// xxh_mul64
// low 64 bits of a 64x64 product, built from three 32x32 partial products
// on one shared multiplier
// ----------------------------------------------------------------------------
module xxh_mul64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic        busy_q;
  logic [1:0]  step_q;
  logic        done_q;
  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] p_q;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  assign op_a = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign op_b = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
  assign prod = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q) begin
      case (step_q)
        2'd0:    p_q <= prod;
        default: p_q <= {p_q[63:32] + prod[31:0], p_q[31:0]};
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier restarted while busy");

  a_done_after_last_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == 2'd2 && !start_i) |=> done_q)
    else $error("multiplier missed its done pulse");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done raised while still busy");

endmodule

FILE: hdl/xxh_datapath.sv
// ----------------------------------------------------------------------------
// xxh_datapath
// seed, lane accumulators, stripe buffer, length counter, working and hash
// registers, driven one command per cycle
// ----------------------------------------------------------------------------
module xxh_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [63:0]      cfg_data_i,
  input  logic [63:0]      data_word_i,
  input  logic [3:0]       byte_count_i,
  input  logic             last_word_i,
  input  xxh_pkg::cmd_t    cmd_i,
  output xxh_pkg::status_t status_o,
  output logic [63:0]      digest_o
);

  logic [63:0] seed_q;
  logic [63:0] lane_q [4];
  logic [63:0] buf_q [4];
  logic [1:0]  buffered_q;
  logic [63:0] total_q;
  logic [63:0] tail_q;
  logic [3:0]  tail_n_q;
  logic [63:0] x_q;
  logic [63:0] x_d;
  logic [63:0] h_q;
  logic [63:0] h_d;
  logic [63:0] digest_q;
  logic [63:0] lane_rd;
  logic [63:0] hx;
  logic [63:0] mrot;
  logic [63:0] mul_p;
  logic        mul_done;
  logic        push;

  function automatic logic [63:0] lane_start(input logic [63:0] s, input logic [1:0] i);
    logic [63:0] v;
    case (i)
      2'd0:    v = s + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
      2'd1:    v = s + xxh_pkg::PRIME2;
      2'd2:    v = s;
      default: v = s - xxh_pkg::PRIME1;
    endcase
    return v;
  endfunction

  xxh_mul64 u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (x_q),
    .b_i     (xxh_pkg::kval(cmd_i.ksel)),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign push    = !last_word_i || byte_count_i[3];
  assign lane_rd = lane_q[cmd_i.idx[1:0]];
  assign hx      = h_q ^ x_q;

  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    mrot = xxh_pkg::rotl64(lane_rd, 1);
      2'd1:    mrot = xxh_pkg::rotl64(lane_rd, 7);
      2'd2:    mrot = xxh_pkg::rotl64(lane_rd, 12);
      default: mrot = xxh_pkg::rotl64(lane_rd, 18);
    endcase
  end

  always_comb begin
    x_d = x_q;
    case (cmd_i.x_op)
      xxh_pkg::X_LOAD_BUF:     x_d = buf_q[cmd_i.idx[1:0]];
      xxh_pkg::X_LOAD_LANE:    x_d = lane_rd;
      xxh_pkg::X_LOAD_TAIL32:  x_d = {32'd0, tail_q[31:0]};
      xxh_pkg::X_LOAD_BYTE:    x_d = {56'd0, tail_q[{cmd_i.idx, 3'b000} +: 8]};
      xxh_pkg::X_MUL_RES:      x_d = mul_p;
      xxh_pkg::X_ADD_LANE_ROT: x_d = xxh_pkg::rotl64(x_q + lane_rd, 31);
      xxh_pkg::X_ROT:          x_d = xxh_pkg::rotl64(x_q, 31);
      xxh_pkg::X_MIX: begin
        case (cmd_i.rsel)
          xxh_pkg::R_27: x_d = xxh_pkg::rotl64(hx, 27);
          xxh_pkg::R_23: x_d = xxh_pkg::rotl64(hx, 23);
          xxh_pkg::R_11: x_d = xxh_pkg::rotl64(hx, 11);
          default:       x_d = hx;
        endcase
      end
      xxh_pkg::X_AVAL: begin
        case (cmd_i.shsel)
          xxh_pkg::SH_33: x_d = h_q ^ (h_q >> 33);
          xxh_pkg::SH_29: x_d = h_q ^ (h_q >> 29);
          default:        x_d = h_q ^ (h_q >> 32);
        endcase
      end
      default: x_d = x_q;
    endcase
  end

  always_comb begin
    h_d = h_q;
    case (cmd_i.h_op)
      xxh_pkg::H_MERGE:     h_d = ((cmd_i.idx[1:0] == 2'd0) ? 64'd0 : h_q) + mrot;
      xxh_pkg::H_SEED:      h_d = seed_q + xxh_pkg::PRIME5;
      xxh_pkg::H_ADD_TOTAL: h_d = h_q + total_q;
      xxh_pkg::H_FROM_X:    h_d = x_q + xxh_pkg::cval(cmd_i.csel);
      default:              h_d = h_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= 64'd0;
      buffered_q <= 2'd0;
      total_q    <= 64'd0;
      tail_n_q   <= 4'd0;
      for (int i = 0; i < 4; i++) begin
        lane_q[i] <= lane_start(64'd0, 2'(i));
      end
    end else begin
      if (cfg_we_i) begin
        seed_q     <= cfg_data_i;
        buffered_q <= 2'd0;
        total_q    <= 64'd0;
        for (int i = 0; i < 4; i++) begin
          lane_q[i] <= lane_start(cfg_data_i, 2'(i));
        end
      end else if (cmd_i.restart) begin
        buffered_q <= 2'd0;
        total_q    <= 64'd0;
        for (int i = 0; i < 4; i++) begin
          lane_q[i] <= lane_start(seed_q, 2'(i));
        end
      end else if (cmd_i.accept) begin
        if (push) begin
          buffered_q <= buffered_q + 2'd1;
          total_q    <= total_q + 64'd8;
          tail_n_q   <= 4'd0;
        end else begin
          total_q    <= total_q + {60'd0, byte_count_i};
          tail_n_q   <= byte_count_i;
        end
      end else if (cmd_i.lane_wr) begin
        lane_q[cmd_i.idx[1:0]] <= x_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tail_q <= data_word_i;
      if (push) begin
        buf_q[buffered_q] <= data_word_i;
      end
    end
    x_q <= x_d;
    h_q <= h_d;
    if (cmd_i.out_load) begin
      digest_q <= x_q;
    end
  end

  assign status_o.buffered = buffered_q;
  assign status_o.tail_n   = tail_n_q;
  assign status_o.long_msg = (total_q >= 64'(xxh_pkg::STRIPE_BYTES));
  assign status_o.mul_done = mul_done;
  assign digest_o          = digest_q;

endmodule

FILE: hdl/xxh_ctrl.sv
// ----------------------------------------------------------------------------
// xxh_ctrl
// sequencer for stripe rounds, lane merge, tail rounds and final avalanche;
// owns both handshakes
// ----------------------------------------------------------------------------
module xxh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_word_i,
  input  logic [3:0]       byte_count_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  xxh_pkg::status_t status_i,
  output xxh_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_R_LOAD  = 5'd1;
  localparam logic [4:0] S_R_MULA  = 5'd2;
  localparam logic [4:0] S_R_MID   = 5'd3;
  localparam logic [4:0] S_R_MULB  = 5'd4;
  localparam logic [4:0] S_R_WR    = 5'd5;
  localparam logic [4:0] S_R_MIX   = 5'd6;
  localparam logic [4:0] S_R_MULC  = 5'd7;
  localparam logic [4:0] S_R_FIN   = 5'd8;
  localparam logic [4:0] S_F_START = 5'd9;
  localparam logic [4:0] S_F_MERGE = 5'd10;
  localparam logic [4:0] S_F_TOTAL = 5'd11;
  localparam logic [4:0] S_F_TAIL  = 5'd12;
  localparam logic [4:0] S_A_SHIFT = 5'd13;
  localparam logic [4:0] S_A_MUL   = 5'd14;
  localparam logic [4:0] S_A_STORE = 5'd15;
  localparam logic [4:0] S_OUT     = 5'd16;

  localparam logic [2:0] M_STRIPE = 3'd0;
  localparam logic [2:0] M_MERGE  = 3'd1;
  localparam logic [2:0] M_BUF    = 3'd2;
  localparam logic [2:0] M_TAIL4  = 3'd3;
  localparam logic [2:0] M_BYTE   = 3'd4;

  logic [4:0] state_q, state_d;
  logic [2:0] mode_q, mode_d;
  logic [2:0] idx_q, idx_d;
  logic [1:0] aval_q, aval_d;
  logic       last_q, last_d;
  logic       mul_wait_q, mul_wait_d;
  logic       out_valid_q, out_valid_d;
  logic       push;
  logic       lane_mode;
  xxh_pkg::cmd_t cmd;

  assign push      = !last_word_i || byte_count_i[3];
  assign lane_mode = (mode_q == M_STRIPE) || (mode_q == M_MERGE) || (mode_q == M_BUF);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    idx_d      = idx_q;
    aval_d     = aval_q;
    last_d     = last_q;
    mul_wait_d = mul_wait_q;

    cmd           = '0;
    cmd.x_op      = xxh_pkg::X_HOLD;
    cmd.h_op      = xxh_pkg::H_HOLD;
    cmd.ksel      = xxh_pkg::K_P1;
    cmd.csel      = xxh_pkg::C_ZERO;
    cmd.rsel      = xxh_pkg::R_NONE;
    cmd.shsel     = xxh_pkg::SH_33;
    cmd.idx       = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          last_d     = last_word_i;
          if (push && status_i.buffered == 2'd3) begin
            mode_d  = M_STRIPE;
            idx_d   = 3'd0;
            state_d = S_R_LOAD;
          end else if (last_word_i) begin
            state_d = S_F_START;
          end
        end
      end

      S_R_LOAD: begin
        case (mode_q)
          M_MERGE: cmd.x_op = xxh_pkg::X_LOAD_LANE;
          M_TAIL4: cmd.x_op = xxh_pkg::X_LOAD_TAIL32;
          M_BYTE:  cmd.x_op = xxh_pkg::X_LOAD_BYTE;
          default: cmd.x_op = xxh_pkg::X_LOAD_BUF;
        endcase
        state_d = S_R_MULA;
      end

      S_R_MULA: begin
        case (mode_q)
          M_TAIL4: cmd.ksel = xxh_pkg::K_P1;
          M_BYTE:  cmd.ksel = xxh_pkg::K_P5;
          default: cmd.ksel = xxh_pkg::K_P2;
        endcase
        if (!mul_wait_q) begin
          cmd.mul_start = 1'b1;
          mul_wait_d    = 1'b1;
        end else if (status_i.mul_done) begin
          cmd.x_op   = xxh_pkg::X_MUL_RES;
          mul_wait_d = 1'b0;
          state_d    = lane_mode ? S_R_MID : S_R_MIX;
        end
      end

      S_R_MID: begin
        cmd.x_op = (mode_q == M_STRIPE) ? xxh_pkg::X_ADD_LANE_ROT : xxh_pkg::X_ROT;
        state_d  = S_R_MULB;
      end

      S_R_MULB: begin
        cmd.ksel = xxh_pkg::K_P1;
        if (!mul_wait_q) begin
          cmd.mul_start = 1'b1;
          mul_wait_d    = 1'b1;
        end else if (status_i.mul_done) begin
          cmd.x_op   = xxh_pkg::X_MUL_RES;
          mul_wait_d = 1'b0;
          state_d    = (mode_q == M_STRIPE) ? S_R_WR : S_R_MIX;
        end
      end

      S_R_WR: begin
        cmd.lane_wr = 1'b1;
        if (idx_q == 3'd3) begin
          state_d = last_q ? S_F_START : S_IDLE;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_R_LOAD;
        end
      end

      S_R_MIX: begin
        cmd.x_op = xxh_pkg::X_MIX;
        case (mode_q)
          M_BUF:   cmd.rsel = xxh_pkg::R_27;
          M_TAIL4: cmd.rsel = xxh_pkg::R_23;
          M_BYTE:  cmd.rsel = xxh_pkg::R_11;
          default: cmd.rsel = xxh_pkg::R_NONE;
        endcase
        state_d = S_R_MULC;
      end

      S_R_MULC: begin
        cmd.ksel = (mode_q == M_TAIL4) ? xxh_pkg::K_P2 : xxh_pkg::K_P1;
        if (!mul_wait_q) begin
          cmd.mul_start = 1'b1;
          mul_wait_d    = 1'b1;
        end else if (status_i.mul_done) begin
          cmd.x_op   = xxh_pkg::X_MUL_RES;
          mul_wait_d = 1'b0;
          state_d    = S_R_FIN;
        end
      end

      S_R_FIN: begin
        cmd.h_op = xxh_pkg::H_FROM_X;
        case (mode_q)
          M_TAIL4: cmd.csel = xxh_pkg::C_P3;
          M_BYTE:  cmd.csel = xxh_pkg::C_ZERO;
          default: cmd.csel = xxh_pkg::C_P4;
        endcase
        case (mode_q)
          M_MERGE: begin
            if (idx_q == 3'd3) begin
              state_d = S_F_TOTAL;
            end else begin
              idx_d   = idx_q + 3'd1;
              state_d = S_R_LOAD;
            end
          end
          M_BUF: begin
            if ({1'b0, idx_q[1:0]} + 3'd1 == {1'b0, status_i.buffered}) begin
              state_d = S_F_TAIL;
            end else begin
              idx_d   = idx_q + 3'd1;
              state_d = S_R_LOAD;
            end
          end
          M_TAIL4: begin
            if (status_i.tail_n > 4'd4) begin
              mode_d  = M_BYTE;
              idx_d   = 3'd4;
              state_d = S_R_LOAD;
            end else begin
              state_d = S_A_SHIFT;
            end
          end
          default: begin
            if ({1'b0, idx_q} + 4'd1 == status_i.tail_n) begin
              state_d = S_A_SHIFT;
            end else begin
              idx_d   = idx_q + 3'd1;
              state_d = S_R_LOAD;
            end
          end
        endcase
      end

      S_F_START: begin
        aval_d = 2'd0;
        idx_d  = 3'd0;
        if (status_i.long_msg) begin
          state_d = S_F_MERGE;
        end else begin
          cmd.h_op = xxh_pkg::H_SEED;
          state_d  = S_F_TOTAL;
        end
      end

      S_F_MERGE: begin
        cmd.h_op = xxh_pkg::H_MERGE;
        if (idx_q == 3'd3) begin
          mode_d  = M_MERGE;
          idx_d   = 3'd0;
          state_d = S_R_LOAD;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end

      S_F_TOTAL: begin
        cmd.h_op = xxh_pkg::H_ADD_TOTAL;
        idx_d    = 3'd0;
        if (status_i.buffered != 2'd0) begin
          mode_d  = M_BUF;
          state_d = S_R_LOAD;
        end else begin
          state_d = S_F_TAIL;
        end
      end

      S_F_TAIL: begin
        idx_d = 3'd0;
        if (status_i.tail_n >= 4'd4) begin
          mode_d  = M_TAIL4;
          state_d = S_R_LOAD;
        end else if (status_i.tail_n != 4'd0) begin
          mode_d  = M_BYTE;
          state_d = S_R_LOAD;
        end else begin
          state_d = S_A_SHIFT;
        end
      end

      S_A_SHIFT: begin
        cmd.x_op = xxh_pkg::X_AVAL;
        case (aval_q)
          2'd0:    cmd.shsel = xxh_pkg::SH_33;
          2'd1:    cmd.shsel = xxh_pkg::SH_29;
          default: cmd.shsel = xxh_pkg::SH_32;
        endcase
        state_d = (aval_q == 2'd2) ? S_OUT : S_A_MUL;
      end

      S_A_MUL: begin
        cmd.ksel = (aval_q == 2'd0) ? xxh_pkg::K_P2 : xxh_pkg::K_P3;
        if (!mul_wait_q) begin
          cmd.mul_start = 1'b1;
          mul_wait_d    = 1'b1;
        end else if (status_i.mul_done) begin
          cmd.x_op   = xxh_pkg::X_MUL_RES;
          mul_wait_d = 1'b0;
          state_d    = S_A_STORE;
        end
      end

      S_A_STORE: begin
        cmd.h_op = xxh_pkg::H_FROM_X;
        cmd.csel = xxh_pkg::C_ZERO;
        aval_d   = aval_q + 2'd1;
        state_d  = S_A_SHIFT;
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          cmd.restart  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_STRIPE;
      idx_q       <= 3'd0;
      aval_q      <= 2'd0;
      last_q      <= 1'b0;
      mul_wait_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      aval_q      <= aval_d;
      last_q      <= last_d;
      mul_wait_q  <= mul_wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_wait_in_mul_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_wait_q |-> (state_q == S_R_MULA || state_q == S_R_MULB ||
                    state_q == S_R_MULC || state_q == S_A_MUL))
    else $error("multiply wait flag outside a multiply step");

  a_word_from_out_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("digest word raised outside output step");

  a_lane_write_in_stripe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R_WR) |-> (mode_q == M_STRIPE))
    else $error("lane write outside a stripe round");

endmodule

FILE: hdl/xxh64_stream_hash.sv
// ----------------------------------------------------------------------------
// xxh64_stream_hash
// 64-bit xxhash of a byte stream delivered as little-endian 64-bit words
// ----------------------------------------------------------------------------
// input channel: data_word_i, byte_count_i, last_word_i with in_valid_i /
//   in_stall_o; a word is taken when valid is high and stall is low. all
//   words before the last carry 8 bytes, the last carries 0 to 8
// output channel: digest_o with out_valid_o / out_stall_i, one word per
//   message, held in an output register until taken
// seed: cfg_we_i / cfg_data_i, written while idle; also starts a new message
// stripes: full words are buffered until four complete a 32-byte stripe;
//   that fourth word starts the four lane rounds, each two multiplies on the
//   one shared 32x32 multiplier
// digest: after the last word, the merge (long messages only), tail and
//   avalanche multiplies run on that same multiplier
// in_stall_o is high while a stripe or digest is in progress; a new message
//   can start while the previous digest still waits in the output register
// reset: seed 0, lanes at their start values, empty message, no output word
// ----------------------------------------------------------------------------
module xxh64_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_o
);

  xxh_pkg::cmd_t    cmd;
  xxh_pkg::status_t status;

  xxh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_word_i  (last_word_i),
    .byte_count_i (byte_count_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  xxh_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .digest_o     (digest_o)
  );

endmodule
